// File: rtl/plst_pkg.sv
// Package for the positional list store: record, transaction and status types,
// operation codes and the cell shift commands.
// Depends on nothing; every other file of the block refers to it by scoped names.
package plst_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    // Operation codes of the input transaction.
    localparam logic [2:0] KIND_APPEND  = 3'd0;
    localparam logic [2:0] KIND_INSERT  = 3'd1;
    localparam logic [2:0] KIND_PREPEND = 3'd2;
    localparam logic [2:0] KIND_REMOVE  = 3'd3;
    localparam logic [2:0] KIND_READ    = 3'd4;

    // Command broadcast to every cell of the chain.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } t_cell_op;

    // One stored vehicle record.
    typedef struct packed {
        logic [63:0] name_head;
        logic [47:0] name_tail;
        logic [15:0] year;
        logic [15:0] consumption;
    } t_rec;

    // Input transaction payload.
    typedef struct packed {
        logic [2:0]  kind;
        logic [5:0]  position;
        logic [63:0] name_head;
        logic [47:0] name_tail;
        logic [15:0] year;
        logic [15:0] consumption;
    } t_in_item;

    // Result transaction payload.
    typedef struct packed {
        t_status     status;
        logic [5:0]  count_now;
        logic [5:0]  free_slots;
        logic [63:0] out_name_head;
        logic [47:0] out_name_tail;
        logic [15:0] out_year;
        logic [15:0] out_consumption;
    } t_out_item;

endpackage

// File: rtl/plst_cell.sv
// One slot of the list chain: holds a record and takes it from its left or
// right neighbor, or from the new record, as the broadcast command says.
// Depends on plst_pkg.
module plst_cell #(
    parameter int IW       = 5,
    parameter int CELL_IDX = 0
) (
    input  logic              i_clk,
    input  plst_pkg::t_cell_op i_op,
    input  logic [IW-1:0]     i_idx,
    input  plst_pkg::t_rec    i_new,
    input  plst_pkg::t_rec    i_left,
    input  plst_pkg::t_rec    i_right,
    output plst_pkg::t_rec    o_rec
);

    localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

    plst_pkg::t_rec r_rec;
    plst_pkg::t_rec n_rec;

    // Slots above an insert point shift up and the slot at it takes the new
    // record; slots at and above a removal point take the entry from above.
    always_comb begin
        n_rec = r_rec;
        unique case (i_op)
            plst_pkg::CELL_INSERT: begin
                if (MY_IDX > i_idx) begin
                    n_rec = i_left;
                end else if (MY_IDX == i_idx) begin
                    n_rec = i_new;
                end
            end
            plst_pkg::CELL_REMOVE: begin
                if (MY_IDX >= i_idx) begin
                    n_rec = i_right;
                end
            end
            default: begin
                n_rec = r_rec;
            end
        endcase
    end

    // Record register; payload only, so no reset.
    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_rec = r_rec;

endmodule

// File: rtl/plst_ctrl.sv
// Control of the positional list store: decodes each transaction, keeps the
// entry count, drives the cell command and holds the registered result.
// Depends on plst_pkg.
module plst_ctrl #(
    parameter int CAPACITY = 32,
    parameter int IW       = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  plst_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output plst_pkg::t_out_item o_out_item,
    output plst_pkg::t_cell_op  o_cell_op,
    output logic [IW-1:0]       o_cell_idx,
    output plst_pkg::t_rec      o_new_rec,
    input  plst_pkg::t_rec      i_rd_rec
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_out_valid;
    plst_pkg::t_out_item r_out;
    plst_pkg::t_out_item n_out;

    logic                w_accept;
    logic                w_full;
    logic                w_empty;
    logic                w_pos_ok;
    logic [CW+5:0]       w_pos_wide;
    logic [CW+5:0]       w_cnt_wide;
    logic [IW+6:0]       w_pos_m1;
    logic [IW-1:0]       w_idx_pos;
    logic [CW-1:0]       w_free;
    logic [CW+5:0]       w_cnt_ext;
    logic [CW+5:0]       w_free_ext;
    logic                w_rd_ok;
    plst_pkg::t_status   w_status;
    plst_pkg::t_cell_op  w_op;

    // A new transaction enters whenever the result register is free or is
    // being emptied in the same cycle.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // List condition and position checks against the current count.
    assign w_full     = r_count >= CAP_C;
    assign w_empty    = r_count == '0;
    assign w_pos_wide = {{CW{1'b0}}, i_in_item.position};
    assign w_cnt_wide = {6'b0, r_count};
    assign w_pos_ok   = (i_in_item.position != 6'd0) && (w_pos_wide <= w_cnt_wide);
    assign w_pos_m1   = {{(IW + 1){1'b0}}, i_in_item.position} - (IW + 7)'(1);
    assign w_idx_pos  = w_pos_m1[IW-1:0];

    // Operation decode: status, cell command, index and next count.
    always_comb begin
        w_status   = plst_pkg::ST_OK;
        w_op       = plst_pkg::CELL_HOLD;
        o_cell_idx = w_idx_pos;
        n_count    = r_count;
        w_rd_ok    = 1'b0;
        unique case (i_in_item.kind)
            plst_pkg::KIND_APPEND: begin
                if (w_full) begin
                    w_status = plst_pkg::ST_FULL;
                end else begin
                    w_op       = plst_pkg::CELL_INSERT;
                    o_cell_idx = r_count[IW-1:0];
                    n_count    = r_count + CW'(1);
                end
            end
            plst_pkg::KIND_INSERT: begin
                if (w_full) begin
                    w_status = plst_pkg::ST_FULL;
                end else if (w_empty) begin
                    w_status = plst_pkg::ST_EMPTY;
                end else if (!w_pos_ok) begin
                    w_status = plst_pkg::ST_BADPOS;
                end else begin
                    w_op    = plst_pkg::CELL_INSERT;
                    n_count = r_count + CW'(1);
                end
            end
            plst_pkg::KIND_PREPEND: begin
                if (w_full) begin
                    w_status = plst_pkg::ST_FULL;
                end else begin
                    w_op       = plst_pkg::CELL_INSERT;
                    o_cell_idx = '0;
                    n_count    = r_count + CW'(1);
                end
            end
            plst_pkg::KIND_REMOVE: begin
                if (w_empty) begin
                    w_status = plst_pkg::ST_EMPTY;
                end else if (!w_pos_ok) begin
                    w_status = plst_pkg::ST_BADPOS;
                end else begin
                    w_op    = plst_pkg::CELL_REMOVE;
                    n_count = r_count - CW'(1);
                end
            end
            plst_pkg::KIND_READ: begin
                if (w_empty) begin
                    w_status = plst_pkg::ST_EMPTY;
                end else if (!w_pos_ok) begin
                    w_status = plst_pkg::ST_BADPOS;
                end else begin
                    w_rd_ok = 1'b1;
                end
            end
            default: begin
                w_status = plst_pkg::ST_OK;
            end
        endcase
    end

    // Cells move only on an accepted transaction.
    assign o_cell_op = w_accept ? w_op : plst_pkg::CELL_HOLD;

    assign o_new_rec.name_head   = i_in_item.name_head;
    assign o_new_rec.name_tail   = i_in_item.name_tail;
    assign o_new_rec.year        = i_in_item.year;
    assign o_new_rec.consumption = i_in_item.consumption;

    // Result payload: counts cut to six bits, record only on a good read.
    assign w_free     = CAP_C - n_count;
    assign w_cnt_ext  = {6'b0, n_count};
    assign w_free_ext = {6'b0, w_free};

    always_comb begin
        n_out.status          = w_status;
        n_out.count_now       = w_cnt_ext[5:0];
        n_out.free_slots      = w_free_ext[5:0];
        n_out.out_name_head   = w_rd_ok ? i_rd_rec.name_head : 64'd0;
        n_out.out_name_tail   = w_rd_ok ? i_rd_rec.name_tail : 48'd0;
        n_out.out_year        = w_rd_ok ? i_rd_rec.year : 16'd0;
        n_out.out_consumption = w_rd_ok ? i_rd_rec.consumption : 16'd0;
    end

    // Control registers: entry count and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("entry count above capacity");

    // The count moves only with an accepted transaction.
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_count))
        else $error("entry count changed without a transaction");

    // An append into a list with room grows it by one.
    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_item.kind == plst_pkg::KIND_APPEND && !w_full)
        |=> r_count == $past(r_count) + CW'(1))
        else $error("append did not grow the list");

    // A full status is only reported with the list at capacity.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == plst_pkg::ST_FULL) |-> r_count == CAP_C)
        else $error("full status with room left");

    // Every accepted transaction leaves a result in the output register.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("accepted transaction produced no result");

endmodule

// File: rtl/positional_list_store_top.sv
// Positional list store: an ordered list of up to CAPACITY vehicle records with
// append, insert before a position, prepend, remove and read, one result per
// transaction. The list lives in a chain of cells that all shift in the same
// cycle, and an accepted transaction has its result written to the output
// register; the input takes a new transaction in every cycle in which that
// result is free or being taken. Reads go through one position multiplexer
// over the cells. There is no clearing pass after reset; entries beyond the
// count are never read.
// Depends on plst_pkg, plst_cell and plst_ctrl.
module positional_list_store_top #(
    parameter int CAPACITY = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  plst_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output plst_pkg::t_out_item o_out_item
);

    localparam int IW = $clog2(CAPACITY);

    plst_pkg::t_cell_op w_cell_op;
    logic [IW-1:0]      w_cell_idx;
    plst_pkg::t_rec     w_new_rec;
    plst_pkg::t_rec     w_rd_rec;
    plst_pkg::t_rec     w_cell [CAPACITY];

    // Decode, count and result register.
    plst_ctrl #(
        .CAPACITY (CAPACITY),
        .IW       (IW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .o_cell_op   (w_cell_op),
        .o_cell_idx  (w_cell_idx),
        .o_new_rec   (w_new_rec),
        .i_rd_rec    (w_rd_rec)
    );

    // Chain of record cells; the ends tie to the new record and to themselves.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        plst_pkg::t_rec w_left;
        plst_pkg::t_rec w_right;

        if (g == 0) begin : g_first
            assign w_left = w_new_rec;
        end else begin : g_mid_l
            assign w_left = w_cell[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_cell[g];
        end else begin : g_mid_r
            assign w_right = w_cell[g+1];
        end

        plst_cell #(
            .IW       (IW),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (w_cell_op),
            .i_idx   (w_cell_idx),
            .i_new   (w_new_rec),
            .i_left  (w_left),
            .i_right (w_right),
            .o_rec   (w_cell[g])
        );
    end

    // Read port: the cell at the requested position.
    assign w_rd_rec = w_cell[w_cell_idx];

endmodule
